### hdl/utx_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Unicode transcoder package
// Word formats, format codes and code point limits shared by the transcoder.
// ----------------------------------------------------------------------------
package utx_pkg;

	// Source format codes.
	localparam logic SRC_UTF16 = 1'b0;
	localparam logic SRC_UTF32 = 1'b1;

	// Destination format codes. The unused fourth code behaves as UTF-32.
	localparam logic [1:0] DST_UTF8  = 2'd0;
	localparam logic [1:0] DST_UTF16 = 2'd1;
	localparam logic [1:0] DST_UTF32 = 2'd2;

	// Register indexes on the configuration port.
	localparam logic REG_SOURCE_FORMAT = 1'b0;
	localparam logic REG_DEST_FORMAT   = 1'b1;

	localparam int CP_W = 21;

	localparam logic [31:0] SURR_LO   = 32'h0000_D800;
	localparam logic [31:0] SURR_HI   = 32'h0000_E000;
	localparam logic [31:0] CP_MAX    = 32'h0010_FFFF;
	localparam logic [CP_W-1:0] SUPP_BASE = 21'h01_0000;
	localparam logic [CP_W-1:0] ASCII_MAX = 21'h00_007F;
	localparam logic [CP_W-1:0] TWO_MAX   = 21'h00_07FF;
	localparam logic [CP_W-1:0] BMP_MAX   = 21'h00_FFFF;

	typedef struct packed {
		logic [31:0] src_unit;
		logic        end_of_string;
	} in_word_t;

	typedef struct packed {
		logic [20:0] out_unit;
		logic        unit_present;
		logic        run_last;
		logic        string_done;
		logic        string_ok;
	} out_word_t;

	// One classified code point handed from the front end to the back end.
	typedef struct packed {
		logic [CP_W-1:0] cp;
		logic            has_cp;
		logic            eos;
		logic            ok;
	} job_t;

endpackage

`default_nettype wire

### hdl/utx_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcoder front end
// Accepts source words, pairs surrogates, validates code points and tracks
// the string status. Each word that yields a code point or ends a string
// becomes one job in the queue.
// ----------------------------------------------------------------------------
module utx_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              source_format,
	input  wire logic              in_valid,
	output      logic              in_ready,
	input  wire utx_pkg::in_word_t in_data,
	input  wire logic              q_full,
	output      logic              q_push,
	output      utx_pkg::job_t     q_job
);

	logic [9:0] held_lead_q;
	logic       lead_pending_q;
	logic       all_valid_q;

	logic        accept;
	logic [15:0] u16;
	logic        is_lead;
	logic        is_trail;
	logic        cp32_ok;
	logic        invalid;
	logic        hold_lead;
	logic        has_cp;
	logic [utx_pkg::CP_W-1:0] cp;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign u16      = in_data.src_unit[15:0];
	assign is_lead  = (u16[15:10] == 6'b110110);
	assign is_trail = (u16[15:10] == 6'b110111);
	assign cp32_ok  = (in_data.src_unit < utx_pkg::SURR_LO) ||
		((in_data.src_unit >= utx_pkg::SURR_HI) && (in_data.src_unit <= utx_pkg::CP_MAX));

	always_comb begin
		invalid   = 1'b0;
		hold_lead = 1'b0;
		has_cp    = 1'b0;
		cp        = '0;
		if (source_format == utx_pkg::SRC_UTF32) begin
			// A lead left over from UTF-16 input counts as unpaired.
			if (lead_pending_q)
				invalid = 1'b1;
			if (cp32_ok) begin
				has_cp = 1'b1;
				cp     = in_data.src_unit[utx_pkg::CP_W-1:0];
			end else begin
				invalid = 1'b1;
			end
		end else if (lead_pending_q && is_trail) begin
			has_cp = 1'b1;
			cp     = utx_pkg::SUPP_BASE + {1'b0, held_lead_q, u16[9:0]};
		end else begin
			// An unpaired held lead is dropped and this word is taken fresh.
			if (lead_pending_q)
				invalid = 1'b1;
			if (is_lead) begin
				if (in_data.end_of_string)
					invalid = 1'b1;
				else
					hold_lead = 1'b1;
			end else if (is_trail) begin
				invalid = 1'b1;
			end else begin
				has_cp = 1'b1;
				cp     = {5'b0, u16};
			end
		end
	end

	assign q_push     = accept && (has_cp || in_data.end_of_string);
	assign q_job.cp     = cp;
	assign q_job.has_cp = has_cp;
	assign q_job.eos    = in_data.end_of_string;
	assign q_job.ok     = all_valid_q && !invalid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_lead_q    <= '0;
			lead_pending_q <= 1'b0;
			all_valid_q    <= 1'b1;
		end else if (accept) begin
			if (in_data.end_of_string) begin
				held_lead_q    <= '0;
				lead_pending_q <= 1'b0;
				all_valid_q    <= 1'b1;
			end else begin
				lead_pending_q <= hold_lead;
				if (hold_lead)
					held_lead_q <= u16[9:0];
				if (invalid)
					all_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### hdl/utx_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Job queue
// Small first-in first-out queue of classified code points between the
// front end and the back end.
// ----------------------------------------------------------------------------
module utx_fifo #(
	parameter int DEPTH = 4
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire utx_pkg::job_t push_job,
	output      logic          full,
	input  wire logic          pop,
	output      logic          not_empty,
	output      utx_pkg::job_t head_job
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	utx_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head_job  = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

### hdl/utx_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcoder back end
// Takes one job at a time from the queue, encodes its code point in the
// destination format and issues one output word per cycle while not stalled.
// ----------------------------------------------------------------------------
module utx_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic [1:0]         dest_format,
	input  wire logic               q_valid,
	input  wire utx_pkg::job_t      q_job,
	output      logic               q_pop,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      utx_pkg::out_word_t out_data
);

	utx_pkg::job_t      job_q;
	logic               job_valid_q;
	logic [1:0]         idx_q;
	logic               out_valid_q;
	utx_pkg::out_word_t out_data_q;

	logic [utx_pkg::CP_W-1:0] cp;
	logic [utx_pkg::CP_W-1:0] hi_off;
	logic [utx_pkg::CP_W-1:0] enc [4];
	logic [2:0]               n_units;
	logic [2:0]               total;
	logic                     last;
	logic                     issue;
	utx_pkg::out_word_t       res;

	assign cp     = job_q.cp;
	assign hi_off = cp - utx_pkg::SUPP_BASE;

	always_comb begin
		enc[0]  = cp;
		enc[1]  = '0;
		enc[2]  = '0;
		enc[3]  = '0;
		n_units = 3'd1;
		case (dest_format)
			utx_pkg::DST_UTF8: begin
				if (cp <= utx_pkg::ASCII_MAX) begin
					n_units = 3'd1;
				end else if (cp <= utx_pkg::TWO_MAX) begin
					n_units = 3'd2;
					enc[0]  = {13'b0, 3'b110, cp[10:6]};
					enc[1]  = {13'b0, 2'b10, cp[5:0]};
				end else if (cp <= utx_pkg::BMP_MAX) begin
					n_units = 3'd3;
					enc[0]  = {13'b0, 4'b1110, cp[15:12]};
					enc[1]  = {13'b0, 2'b10, cp[11:6]};
					enc[2]  = {13'b0, 2'b10, cp[5:0]};
				end else begin
					n_units = 3'd4;
					enc[0]  = {13'b0, 5'b11110, cp[20:18]};
					enc[1]  = {13'b0, 2'b10, cp[17:12]};
					enc[2]  = {13'b0, 2'b10, cp[11:6]};
					enc[3]  = {13'b0, 2'b10, cp[5:0]};
				end
			end
			utx_pkg::DST_UTF16: begin
				if (cp > utx_pkg::BMP_MAX) begin
					n_units = 3'd2;
					enc[0]  = {5'b0, 6'b110110, hi_off[19:10]};
					enc[1]  = {5'b0, 6'b110111, cp[9:0]};
				end
			end
			default: begin
				n_units = 3'd1;
			end
		endcase
	end

	// A job without a code point still gives one word that carries the end status.
	assign total = job_q.has_cp ? n_units : 3'd1;
	assign last  = ({1'b0, idx_q} == total - 3'd1);
	assign issue = job_valid_q && (!out_valid_q || out_ready);

	always_comb begin
		res.out_unit     = job_q.has_cp ? enc[idx_q] : '0;
		res.unit_present = job_q.has_cp;
		res.run_last     = last;
		res.string_done  = job_q.eos && last;
		res.string_ok    = job_q.eos && last && job_q.ok;
	end

	assign q_pop     = q_valid && (!job_valid_q || (issue && last));
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (issue)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			if (q_pop) begin
				job_valid_q <= 1'b1;
				idx_q       <= '0;
			end else if (issue && last) begin
				job_valid_q <= 1'b0;
				idx_q       <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			job_q <= q_job;
		if (issue)
			out_data_q <= res;
	end

endmodule

`default_nettype wire

### hdl/unicode_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Unicode transcoder
// UTF-16 or UTF-32 words in, UTF-8, UTF-16 or UTF-32 words out.
// ----------------------------------------------------------------------------
// The front end classifies each input word in the cycle it is accepted and
// queues a word that yields a code point or ends a string as one job; words
// that make no result (a held lead surrogate, a dropped invalid unit) stay in
// the front end. The back end issues one output word per cycle, unless the
// receiver stalls, from its output register, as many per job as results it
// makes: one for ASCII or any UTF-32 output, two or three for BMP characters
// in UTF-8, four for a supplementary character in UTF-8. The back end sets
// the sustained rate; the job queue lets the front end keep accepting words
// while a long UTF-8 sequence drains. An accepted word passes the job queue
// and the back end's job and output registers. Registers: source_format at
// 0x0, dest_format at 0x4; write them only while no string is in flight.
// ----------------------------------------------------------------------------
module unicode_transcoder #(
	parameter int FIFO_DEPTH = 4
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire utx_pkg::in_word_t  in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      utx_pkg::out_word_t out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output      logic [31:0]        prdata,
	output      logic               pready
);

	logic          source_format_q;
	logic [1:0]    dest_format_q;
	logic          reg_wr;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_valid;
	utx_pkg::job_t push_job;
	utx_pkg::job_t head_job;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_format_q <= utx_pkg::SRC_UTF16;
			dest_format_q   <= utx_pkg::DST_UTF8;
		end else if (reg_wr) begin
			if (paddr[2] == utx_pkg::REG_SOURCE_FORMAT)
				source_format_q <= pwdata[0];
			else
				dest_format_q <= pwdata[1:0];
		end
	end

	assign prdata = (paddr[2] == utx_pkg::REG_SOURCE_FORMAT) ?
		{31'b0, source_format_q} : {30'b0, dest_format_q};

	utx_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.source_format (source_format_q),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_job         (push_job)
	);

	utx_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_job  (push_job),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.head_job  (head_job)
	);

	utx_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dest_format (dest_format_q),
		.q_valid     (q_valid),
		.q_job       (head_job),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire

### hdl/utx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Transcoder port checker
// Watches the output channel of the transcoder for word format and stall rules.
// ----------------------------------------------------------------------------
module utx_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               out_valid,
	input wire logic               out_ready,
	input wire utx_pkg::out_word_t out_data
);

	// A stalled word stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output word changed while stalled");

	a_ok_needs_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_ok |-> out_data.string_done)
		else $error("string_ok without string_done");

	// A word without a unit only ever carries the end status.
	a_empty_is_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.unit_present |->
			out_data.string_done && out_data.run_last && out_data.out_unit == '0)
		else $error("empty output word that is not an end word");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.string_done |-> out_data.run_last)
		else $error("string_done before the last word of a run");

endmodule

bind unicode_transcoder utx_checker u_utx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

`default_nettype wire

### bench/utx_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Unicode transcoder scoreboard
// Watches the input, output and register ports of the transcoder. It tracks
// the surrogate and validity state of the current string and works out the
// output words that each accepted input word must produce. Each accepted
// output word is compared field by field with the oldest outstanding one.
// ----------------------------------------------------------------------------
module utx_scoreboard (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire utx_pkg::in_word_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire utx_pkg::out_word_t out_data,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output int                      n_waiting,
	output int                      n_failures
);

	localparam int              CP_W       = utx_pkg::CP_W;
	localparam logic [5:0]      LEAD_TAG   = 6'b110110;
	localparam logic [5:0]      TRAIL_TAG  = 6'b110111;
	localparam logic [CP_W-1:0] TRAIL_BASE = 21'h00_DC00;

	logic       src_fmt;
	logic [1:0] dst_fmt;
	logic [9:0] held_lead;
	logic       lead_pending;
	logic       all_valid;

	utx_pkg::out_word_t out_words_due[$];

	// Splits one code point into destination units; returns how many.
	function automatic int encode_char(input logic [1:0] fmt, input logic [CP_W-1:0] cp,
			output logic [3:0][CP_W-1:0] units);
		logic [CP_W-1:0] v;
		units = '0;
		// Only the upper bit is decoded, so the unused fourth code is UTF-32.
		if (fmt[1]) begin
			units[0] = cp;
			return 1;
		end
		if (fmt == utx_pkg::DST_UTF16) begin
			if (cp <= utx_pkg::BMP_MAX) begin
				units[0] = cp;
				return 1;
			end
			v = cp - utx_pkg::SUPP_BASE;
			units[0] = utx_pkg::SURR_LO[CP_W-1:0] + v[19:10];
			units[1] = TRAIL_BASE + v[9:0];
			return 2;
		end
		if (cp <= utx_pkg::ASCII_MAX) begin
			units[0] = cp;
			return 1;
		end
		if (cp <= utx_pkg::TWO_MAX) begin
			units[0] = 21'h0C0 | (cp >> 6);
			units[1] = 21'h080 | (cp & 21'h3F);
			return 2;
		end
		if (cp <= utx_pkg::BMP_MAX) begin
			units[0] = 21'h0E0 | (cp >> 12);
			units[1] = 21'h080 | ((cp >> 6) & 21'h3F);
			units[2] = 21'h080 | (cp & 21'h3F);
			return 3;
		end
		units[0] = 21'h0F0 | ((cp >> 18) & 21'h07);
		units[1] = 21'h080 | ((cp >> 12) & 21'h3F);
		units[2] = 21'h080 | ((cp >> 6) & 21'h3F);
		units[3] = 21'h080 | (cp & 21'h3F);
		return 4;
	endfunction

	task automatic transcode_word(input utx_pkg::in_word_t w);
		logic [3:0][CP_W-1:0] units;
		logic [15:0]          u;
		logic                 fresh;
		logic                 last;
		utx_pkg::out_word_t   r;
		int                   n;
		int                   total;
		int                   k;
		n = 0;
		fresh = 1'b1;
		u = w.src_unit[15:0];
		if (src_fmt == utx_pkg::SRC_UTF32) begin
			// A lead left over from UTF-16 input can never be paired now.
			if (lead_pending) begin
				lead_pending = 1'b0;
				all_valid = 1'b0;
			end
			if (w.src_unit < utx_pkg::SURR_LO ||
					(w.src_unit >= utx_pkg::SURR_HI && w.src_unit <= utx_pkg::CP_MAX)) begin
				n = encode_char(dst_fmt, w.src_unit[CP_W-1:0], units);
			end else begin
				all_valid = 1'b0;
			end
		end else begin
			if (lead_pending) begin
				lead_pending = 1'b0;
				if (u[15:10] == TRAIL_TAG) begin
					n = encode_char(dst_fmt, utx_pkg::SUPP_BASE + {held_lead, u[9:0]}, units);
					fresh = 1'b0;
				end else begin
					all_valid = 1'b0;
				end
			end
			if (fresh) begin
				if (u[15:10] == LEAD_TAG) begin
					if (w.end_of_string) begin
						all_valid = 1'b0;
					end else begin
						held_lead = u[9:0];
						lead_pending = 1'b1;
					end
				end else if (u[15:10] == TRAIL_TAG) begin
					all_valid = 1'b0;
				end else begin
					n = encode_char(dst_fmt, {5'd0, u}, units);
				end
			end
		end

		// An end of string with nothing emitted still reports its status.
		total = (w.end_of_string && n == 0) ? 1 : n;
		for (k = 0; k < total; k++) begin
			last = (k == total - 1);
			r.out_unit = (k < n) ? units[k] : '0;
			r.unit_present = (k < n);
			r.run_last = last;
			r.string_done = w.end_of_string && last;
			r.string_ok = w.end_of_string && last && all_valid;
			out_words_due = {out_words_due, r};
		end
		if (w.end_of_string) begin
			held_lead = '0;
			lead_pending = 1'b0;
			all_valid = 1'b1;
		end
	endtask

	task automatic compare_out_word(input utx_pkg::out_word_t got);
		utx_pkg::out_word_t want;
		logic               bad;
		if (out_words_due.size() == 0) begin
			$error("output word %h with none outstanding", got);
			n_failures++;
			return;
		end
		want = out_words_due.pop_front();
		bad = 1'b0;
		if (got.out_unit !== want.out_unit) begin
			$error("out_unit: expected %h, got %h", want.out_unit, got.out_unit);
			bad = 1'b1;
		end
		if (got.unit_present !== want.unit_present) begin
			$error("unit_present: expected %b, got %b", want.unit_present, got.unit_present);
			bad = 1'b1;
		end
		if (got.run_last !== want.run_last) begin
			$error("run_last: expected %b, got %b", want.run_last, got.run_last);
			bad = 1'b1;
		end
		if (got.string_done !== want.string_done) begin
			$error("string_done: expected %b, got %b", want.string_done, got.string_done);
			bad = 1'b1;
		end
		if (got.string_ok !== want.string_ok) begin
			$error("string_ok: expected %b, got %b", want.string_ok, got.string_ok);
			bad = 1'b1;
		end
		if (bad) begin
			n_failures++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_fmt = utx_pkg::SRC_UTF16;
			dst_fmt = utx_pkg::DST_UTF8;
			held_lead = '0;
			lead_pending = 1'b0;
			all_valid = 1'b1;
			out_words_due.delete();
			n_waiting = 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == utx_pkg::REG_DEST_FORMAT) begin
					dst_fmt = pwdata[1:0];
				end else begin
					src_fmt = pwdata[0];
				end
			end
			if (in_valid && in_ready) begin
				transcode_word(in_data);
			end
			if (out_valid && out_ready) begin
				compare_out_word(out_data);
			end
			n_waiting = out_words_due.size();
		end
	end

endmodule

`default_nettype wire

### bench/tb_unicode_transcoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Unicode transcoder testbench
// Drives UTF-16 and UTF-32 strings through the transcoder under every format
// setting: a directed set of boundary characters and surrogate corner cases,
// then random strings with occasional invalid words, under several patterns
// of sender gaps and receiver stalls. A separate checker predicts and
// compares the output words.
// ----------------------------------------------------------------------------
module tb_unicode_transcoder;

	localparam int         CP_W            = utx_pkg::CP_W;
	localparam int         CYCLE_LIMIT     = 200000;
	localparam int         SETTLE_CYCLES   = 12;
	localparam int         HOLD_OFF_CYCLES = 150;
	localparam logic [5:0] LEAD_TAG        = 6'b110110;
	localparam logic [5:0] TRAIL_TAG       = 6'b110111;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	utx_pkg::in_word_t  in_data;
	logic               out_valid;
	logic               out_ready;
	utx_pkg::out_word_t out_data;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [2:0]         paddr;
	logic [31:0]        pwdata;
	logic [31:0]        prdata;
	logic               pready;

	int n_waiting;
	int n_failures;
	int send_idle_pct;
	int recv_stall_pct;
	int hold_requests;
	int words_sent;
	int cycles;

	unicode_transcoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	utx_scoreboard check_unit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.n_waiting  (n_waiting),
		.n_failures (n_failures)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb_unicode_transcoder failed");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off whenever one is requested.
	initial begin : receiver
		int hold_served;
		int hold_left;
		hold_served = 0;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic utx_pkg::in_word_t unit_word(input logic [31:0] unit, input logic eos);
		return {unit, eos};
	endfunction

	task automatic write_reg(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(input utx_pkg::in_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Words that produce nothing may still be in flight when the last output
	// word arrives, so drain waits out SETTLE_CYCLES before the block counts as idle.
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (n_waiting != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic run_phase(input logic src, input logic [1:0] dst, input int idle_pct,
			input int stall_pct, input int n_words);
		int              target;
		int              len;
		int              k;
		int              roll;
		logic            eos;
		logic [CP_W-1:0] cp;
		logic [CP_W-1:0] v;
		logic [31:0]     unit;
		write_reg(utx_pkg::REG_SOURCE_FORMAT, {31'd0, src});
		write_reg(utx_pkg::REG_DEST_FORMAT, {30'd0, dst});
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		target = words_sent + n_words;
		while (words_sent < target) begin
			len = $urandom_range(6, 1);
			for (k = 0; k < len; k++) begin
				eos = (k == len - 1);
				roll = $urandom_range(99);
				if (roll < 12) begin
					// Noise: lone surrogates, or values outside the code point range.
					unit = $urandom();
					if (src == utx_pkg::SRC_UTF16) begin
						unit[15:0] = utx_pkg::SURR_LO[15:0] + 16'($urandom_range(2047));
					end else if (roll < 6) begin
						unit = utx_pkg::SURR_LO + $urandom_range(2047);
					end
					send_word(unit_word(unit, eos));
				end else begin
					case ($urandom_range(3))
						0: cp = CP_W'($urandom_range(127));
						1: cp = CP_W'($urandom_range(2047, 128));
						2: begin
							cp = CP_W'($urandom_range(65535, 2048));
							// Move anything in the surrogate block up into the private area.
							if (cp[15:11] == 5'b11011) begin
								cp[15:11] = 5'b11100;
							end
						end
						default: begin
							cp = CP_W'($urandom_range(utx_pkg::CP_MAX, utx_pkg::SUPP_BASE));
						end
					endcase
					// The upper half is random noise that UTF-16 input must ignore.
					unit = $urandom();
					if (src == utx_pkg::SRC_UTF32) begin
						send_word(unit_word({11'd0, cp}, eos));
					end else if (cp > utx_pkg::BMP_MAX) begin
						v = cp - utx_pkg::SUPP_BASE;
						send_word(unit_word({unit[31:16], LEAD_TAG, v[19:10]}, 1'b0));
						send_word(unit_word({unit[15:0], TRAIL_TAG, v[9:0]}, eos));
					end else begin
						send_word(unit_word({unit[31:16], cp[15:0]}, eos));
					end
				end
			end
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_idle_pct = 16;
		recv_stall_pct = 16;
		hold_requests = 0;
		words_sent = 0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Reset formats: UTF-16 in, UTF-8 out. Length boundaries of UTF-8.
		send_word(unit_word(32'h0000_0000, 1'b0));
		send_word(unit_word(32'h0000_007F, 1'b0));
		send_word(unit_word(32'h0000_0080, 1'b0));
		send_word(unit_word(32'h0000_07FF, 1'b0));
		send_word(unit_word(32'h0000_0800, 1'b0));
		send_word(unit_word(32'h0000_FFFF, 1'b1));
		// Lowest and highest surrogate pairs.
		send_word(unit_word(32'h0000_D800, 1'b0));
		send_word(unit_word(32'h0000_DC00, 1'b0));
		send_word(unit_word(32'h0000_DBFF, 1'b0));
		send_word(unit_word(32'h0000_DFFF, 1'b1));
		// A lone trail, then a lead followed by a plain character.
		send_word(unit_word(32'h0000_DC00, 1'b0));
		send_word(unit_word(32'h0000_0041, 1'b1));
		send_word(unit_word(32'h0000_D83D, 1'b0));
		send_word(unit_word(32'h0000_0042, 1'b1));
		// A lead that ends the string leaves only the end status.
		send_word(unit_word(32'h0000_DBFF, 1'b1));
		send_word(unit_word(32'hFFFF_0041, 1'b1));
		// A lead still held when the source switches to UTF-32 is dropped.
		send_word(unit_word(32'h0000_D801, 1'b0));
		drain();
		write_reg(utx_pkg::REG_SOURCE_FORMAT, {31'd0, utx_pkg::SRC_UTF32});
		write_reg(utx_pkg::REG_DEST_FORMAT, {30'd0, utx_pkg::DST_UTF32});
		send_word(unit_word(32'h0010_FFFF, 1'b1));
		drain();
		// UTF-32 in, UTF-16 out: a pair, then surrogates and out-of-range values.
		write_reg(utx_pkg::REG_DEST_FORMAT, {30'd0, utx_pkg::DST_UTF16});
		send_word(unit_word(32'h0001_0000, 1'b0));
		send_word(unit_word(32'h0000_D800, 1'b0));
		send_word(unit_word(32'h0000_DFFF, 1'b0));
		send_word(unit_word(32'h0011_0000, 1'b0));
		send_word(unit_word(32'hFFFF_FFFF, 1'b0));
		send_word(unit_word(32'h0000_E000, 1'b1));
		drain();

		// The first phase starts behind a long receiver hold-off so the block fills.
		hold_requests++;
		run_phase(utx_pkg::SRC_UTF16, utx_pkg::DST_UTF8, 0, 0, 36);
		run_phase(utx_pkg::SRC_UTF16, utx_pkg::DST_UTF16, 75, 0, 34);
		run_phase(utx_pkg::SRC_UTF16, utx_pkg::DST_UTF32, 0, 75, 34);
		run_phase(utx_pkg::SRC_UTF32, utx_pkg::DST_UTF8, 16, 16, 34);
		run_phase(utx_pkg::SRC_UTF32, utx_pkg::DST_UTF16, 0, 0, 34);
		run_phase(utx_pkg::SRC_UTF32, utx_pkg::DST_UTF32, 75, 0, 34);
		// The unused fourth destination code.
		run_phase(utx_pkg::SRC_UTF16, utx_pkg::DST_UTF16 | utx_pkg::DST_UTF32, 0, 75, 32);
		run_phase(utx_pkg::SRC_UTF32, utx_pkg::DST_UTF16 | utx_pkg::DST_UTF32, 16, 16, 32);
		run_phase(utx_pkg::SRC_UTF16, utx_pkg::DST_UTF8, 16, 16, 32);

		if (n_failures == 0) begin
			$display("tb_unicode_transcoder passed");
		end else begin
			$display("tb_unicode_transcoder failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
